// ===== rtl/crid_pkg.sv =====
`timescale 1ns / 1ps
package crid_pkg;

    localparam int DEF_MAX_WIDTH       = 512;
    localparam int DEF_MAX_HEIGHT      = 256;
    localparam int DEF_PIXELS_PER_WORD = 8;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_XOR_MASK     = 2'd2;

    localparam logic [9:0] RST_IMAGE_WIDTH  = 10'd320;
    localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd200;
    localparam logic [7:0] RST_XOR_MASK     = 8'hFF;

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_image;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [13:0] word_index;
        logic [3:0]  valid_count;
        logic        image_done;
        logic        end_of_item;
    } t_out_item;

endpackage

// ===== rtl/crid_ram.sv =====
`timescale 1ns / 1ps
module crid_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/column_rle_image_decoder_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_stall      i_in_data  (stream_byte, start_of_image)
// out       out  o_out_valid / i_out_stall    o_out_data (pixel_word .. end_of_item)
// config    in   APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A byte that starts no run is handled in IDLE; a run passes RD then PIX per
// pixel, a read then a write-back of the single column store RAM. A final item
// flush passes FLUSH. The block takes no new item until done.
// Reset is synchronous; the column store is not cleared.
// A stalled output holds the sequencer whenever a finished word has nowhere to go.
module column_rle_image_decoder_top #(
    parameter int MAX_WIDTH       = crid_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = crid_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  crid_pkg::t_in_item        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output crid_pkg::t_out_item       o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [crid_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import crid_pkg::*;

    localparam int PIXELS_PER_WORD = DEF_PIXELS_PER_WORD;
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int WCW  = (CW > 10) ? CW : 10;
    localparam int HC   = $clog2(MAX_HEIGHT + 1);
    localparam int HCW  = (HC > 9) ? HC : 9;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CNTW = $clog2(PIXELS_PER_WORD + 1);
    localparam int IW   = (PIXELS_PER_WORD > 1) ? $clog2(PIXELS_PER_WORD) : 1;
    localparam int PKW  = 4 * PIXELS_PER_WORD;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_PIX   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [9:0] r_cfg_w;
    logic [8:0] r_cfg_h;
    logic [7:0] r_mask;

    logic [1:0]      r_state, n_state;
    logic [1:0]      r_phase, n_phase;
    logic            r_copy, n_copy;
    logic [3:0]      r_color, n_color;
    logic [WCW-1:0]  r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [7:0]      r_len, n_len;
    logic [PKW-1:0]  r_pack, n_pack;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [13:0]     r_wcnt, n_wcnt;
    t_out_item       r_hold, n_hold;
    logic            r_hold_v, n_hold_v;
    t_out_item       r_out;
    logic            r_out_v;

    logic [WCW-1:0]  w_eff, w_ext;
    logic [HCW-1:0]  h_eff, h_ext;
    logic            in_acc, out_free, out_load;
    t_out_item       out_nx;
    logic [7:0]      b;
    logic [7:0]      len_c;
    logic [3:0]      pix, ram_rdata;
    logic            ram_we;
    logic [CNTW-1:0] cnt1;
    logic [PKW-1:0]  pack1;
    logic [HCW-1:0]  row1;
    logic [RW-1:0]   row_nx;
    logic [WCW-1:0]  col1;
    logic [7:0]      len1;
    logic            done, emit;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_IMAGE_WIDTH;
            r_cfg_h <= RST_IMAGE_HEIGHT;
            r_mask  <= RST_XOR_MASK;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_cfg_w <= pwdata[9:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= pwdata[8:0];
                REG_XOR_MASK:     r_mask  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_cfg_w);
            REG_IMAGE_HEIGHT: prdata = 32'(r_cfg_h);
            REG_XOR_MASK:     prdata = 32'(r_mask);
            default:          prdata = 32'd0;
        endcase
    end

    // clamped dimensions
    always_comb begin
        w_ext = WCW'(r_cfg_w);
        h_ext = HCW'(r_cfg_h);
        if (r_cfg_w == 10'd0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_cfg_h == 9'd0) begin
            h_eff = HCW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    crid_ram #(
        .WIDTH(4),
        .DEPTH(MAX_HEIGHT)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_row),
        .i_wdata(pix),
        .i_raddr(r_row),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_v || !i_out_stall;

    // per-pixel datapath
    always_comb begin
        if (r_copy) begin
            pix = (r_col == '0) ? 4'd0 : ram_rdata;
        end else begin
            pix = r_color;
        end
        cnt1  = r_cnt + CNTW'(1);
        pack1 = r_pack;
        pack1[4 * r_cnt[IW-1:0] +: 4] = pix;
        row1  = HCW'(r_row) + HCW'(1);
        if (row1 >= h_eff) begin
            row_nx = '0;
            col1   = r_col + WCW'(1);
        end else begin
            row_nx = row1[RW-1:0];
            col1   = r_col;
        end
        done = (col1 >= w_eff);
        emit = (cnt1 >= CNTW'(PIXELS_PER_WORD)) || done;
        len1 = r_len - 8'd1;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_copy   = r_copy;
        n_color  = r_color;
        n_col    = r_col;
        n_row    = r_row;
        n_len    = r_len;
        n_pack   = r_pack;
        n_cnt    = r_cnt;
        n_wcnt   = r_wcnt;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        out_load = 1'b0;
        out_nx   = r_hold;
        ram_we   = 1'b0;
        b        = i_in_data.stream_byte ^ r_mask;
        len_c    = 8'd0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.start_of_image) begin
                        n_phase = PH_CMD;
                        n_copy  = 1'b0;
                        n_color = 4'd0;
                        n_col   = '0;
                        n_row   = '0;
                        n_pack  = '0;
                        n_cnt   = '0;
                        n_wcnt  = 14'd0;
                    end
                    if (n_phase != PH_DONE && n_col >= w_eff) begin
                        n_phase = PH_DONE;
                        if (n_cnt != '0) begin
                            n_hold.pixel_word  = 32'(n_pack);
                            n_hold.word_index  = n_wcnt;
                            n_hold.valid_count = 4'(n_cnt);
                            n_hold.image_done  = 1'b1;
                            n_hold.end_of_item = 1'b0;
                            n_hold_v = 1'b1;
                            n_wcnt   = n_wcnt + 14'd1;
                            n_pack   = '0;
                            n_cnt    = '0;
                            n_state  = S_FLUSH;
                        end
                    end else if (n_phase == PH_CMD) begin
                        if (!b[7]) begin
                            n_copy  = 1'b0;
                            n_color = b[3:0];
                            len_c   = {4'd0, b[7:4]};
                        end else begin
                            n_copy = 1'b1;
                            len_c  = {1'b0, b[6:0]};
                        end
                        if (len_c == 8'd0) begin
                            n_phase = PH_LEN;
                        end else begin
                            n_len   = len_c;
                            n_state = S_RD;
                        end
                    end else if (n_phase == PH_LEN) begin
                        n_phase = PH_CMD;
                        if (b != 8'd0) begin
                            n_len   = b;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_PIX;
            end
            S_PIX: begin
                if (!(emit && r_hold_v && !out_free)) begin
                    ram_we = 1'b1;
                    n_row  = row_nx;
                    n_col  = col1;
                    n_len  = len1;
                    if (emit) begin
                        if (r_hold_v) begin
                            out_load = 1'b1;
                        end
                        n_hold.pixel_word  = 32'(pack1);
                        n_hold.word_index  = r_wcnt;
                        n_hold.valid_count = 4'(cnt1);
                        n_hold.image_done  = done;
                        n_hold.end_of_item = 1'b0;
                        n_hold_v = 1'b1;
                        n_wcnt   = r_wcnt + 14'd1;
                        n_pack   = '0;
                        n_cnt    = '0;
                    end else begin
                        n_pack = pack1;
                        n_cnt  = cnt1;
                    end
                    if (done) begin
                        n_phase = PH_DONE;
                    end
                    if (len1 != 8'd0 && !done) begin
                        n_state = S_RD;
                    end else if (emit || r_hold_v) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_nx.end_of_item = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_CMD;
            r_copy   <= 1'b0;
            r_color  <= 4'd0;
            r_col    <= '0;
            r_row    <= '0;
            r_len    <= 8'd0;
            r_pack   <= '0;
            r_cnt    <= '0;
            r_wcnt   <= 14'd0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_copy   <= n_copy;
            r_color  <= n_color;
            r_col    <= n_col;
            r_row    <= n_row;
            r_len    <= n_len;
            r_pack   <= n_pack;
            r_cnt    <= n_cnt;
            r_wcnt   <= n_wcnt;
            r_hold_v <= n_hold_v;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (out_load) begin
            r_out <= out_nx;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
endmodule
